### rtl/core/fcc_pkg.sv
// Shared types, codes and constants of the FAT cluster chain reader.
`default_nettype none

package fcc_pkg;

  // Default size of the FAT byte store.
  localparam int FatBytesDefault = 16384;

  // Width of a byte offset into the FAT, with room for the second byte of an entry.
  localparam int AT_W = 18;

  // Item actions.
  localparam logic [1:0] ACT_LOAD = 2'd0;
  localparam logic [1:0] ACT_OPEN = 2'd1;
  localparam logic [1:0] ACT_READ = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_GIVEN = 2'd0;
  localparam logic [1:0] ST_END   = 2'd1;
  localparam logic [1:0] ST_BAD   = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_FORMAT   = 2'd0;
  localparam logic [1:0] REG_SPC      = 2'd1;
  localparam logic [1:0] REG_DATA_ST  = 2'd2;
  localparam logic [1:0] REG_CL_BYTES = 2'd3;

  // End-of-chain marks and the FAT12 entry mask.
  localparam logic [15:0] FAT12_EOC  = 16'h0FF8;
  localparam logic [15:0] FAT16_EOC  = 16'hFFF8;
  localparam logic [15:0] FAT12_MASK = 16'h0FFF;

  typedef struct packed {
    logic [1:0]  action;
    logic [13:0] fat_index;
    logic [7:0]  fat_byte;
    logic [15:0] start_cluster;
    logic [31:0] file_size;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [23:0] sector_address;
    logic [7:0]  sector_count;
    logic [16:0] byte_count;
    logic [15:0] next_cluster;
  } result_t;

  typedef struct packed {
    logic        fat16;
    logic [7:0]  sectors_per_cluster;
    logic [15:0] data_start_sector;
    logic [16:0] cluster_bytes;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic commit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } stat_t;

  typedef enum logic [0:0] {
    S_IDLE,
    S_EXEC
  } state_t;

endpackage

`default_nettype wire

### rtl/core/fcc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module fcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/core/fcc_regs.sv
// Configuration registers behind the APB-style port.
`default_nettype none

module fcc_regs
  import fcc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output cfg_t             cfg
);

  logic [1:0] reg_idx;

  assign reg_idx = paddr[3:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fat16               <= 1'b0;
      cfg.sectors_per_cluster <= 8'd1;
      cfg.data_start_sector   <= 16'd0;
      cfg.cluster_bytes       <= 17'd512;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_FORMAT:   cfg.fat16               <= pwdata[0];
        REG_SPC:      cfg.sectors_per_cluster <= pwdata[7:0];
        REG_DATA_ST:  cfg.data_start_sector   <= pwdata[15:0];
        REG_CL_BYTES: cfg.cluster_bytes       <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FORMAT:   prdata = {31'd0, cfg.fat16};
      REG_SPC:      prdata = {24'd0, cfg.sectors_per_cluster};
      REG_DATA_ST:  prdata = {16'd0, cfg.data_start_sector};
      REG_CL_BYTES: prdata = {15'd0, cfg.cluster_bytes};
      default:      prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/fcc_ctrl.sv
// Controller state machine: accepts one item, then commits its result.
`default_nettype none

module fcc_ctrl
  import fcc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  item_valid,
  output logic       item_stall,
  input  wire stat_t st,
  output cmd_t       cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    item_stall  = 1'b1;
    case (state)
      S_IDLE: begin
        item_stall = 1'b0;
        if (item_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        // The FAT bytes are on the RAM outputs now; wait only for room downstream.
        if (st.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/fcc_dpath.sv
// Datapath: FAT byte banks, chain state, result logic and the output register.
`default_nettype none

module fcc_dpath
  import fcc_pkg::*;
#(
  parameter int FAT_BYTES = FatBytesDefault
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire item_t item,
  input  wire cfg_t  cfg,
  input  wire cmd_t  cmd,
  output stat_t      st,
  output logic       result_valid,
  input  wire logic  result_stall,
  output result_t    result
);

  localparam int BankDepth = FAT_BYTES / 2;
  localparam int BAW       = $clog2(BankDepth);

  logic [15:0] cur;
  logic [31:0] left;
  logic [1:0]  act;
  logic [15:0] start_q;
  logic [31:0] size_q;

  logic [AT_W-1:0] at, at1, idx_ext;
  logic            load_we;
  logic [7:0]      even_q, odd_q;
  logic [15:0]     word, entry, next_cl;
  logic            at_end, at_bad;
  logic [23:0]     prod, sector;
  logic [16:0]     actual;
  result_t         res;

  // Even bytes live in one bank and odd bytes in the other, so both bytes of
  // an entry come out in one read.
  assign idx_ext = AT_W'(item.fat_index);
  assign load_we = cmd.capture && (item.action == ACT_LOAD)
                   && (32'(item.fat_index) < 32'(FAT_BYTES));

  assign at  = cfg.fat16 ? AT_W'({cur, 1'b0}) : AT_W'(cur) + AT_W'(cur[15:1]);
  assign at1 = at + AT_W'(1);

  fcc_ram #(.WIDTH(8), .DEPTH(BankDepth)) u_even (
    .clk   (clk),
    .we    (load_we && !item.fat_index[0]),
    .waddr (idx_ext[BAW:1]),
    .wdata (item.fat_byte),
    .raddr (at1[BAW:1]),
    .rdata (even_q)
  );

  fcc_ram #(.WIDTH(8), .DEPTH(BankDepth)) u_odd (
    .clk   (clk),
    .we    (load_we && item.fat_index[0]),
    .waddr (idx_ext[BAW:1]),
    .wdata (item.fat_byte),
    .raddr (at[BAW:1]),
    .rdata (odd_q)
  );

  always_comb begin
    word    = at[0] ? {even_q, odd_q} : {odd_q, even_q};
    entry   = cur[0] ? {4'd0, word[15:4]} : word;
    next_cl = cfg.fat16 ? word : (entry & FAT12_MASK);

    at_end = (cfg.fat16 ? (cur >= FAT16_EOC) : (cur >= FAT12_EOC)) || (left == 32'd0);
    at_bad = (cur < 16'd2) || (at1 >= AT_W'(FAT_BYTES));

    prod   = 24'(cur - 16'd2) * 24'(cfg.sectors_per_cluster);
    sector = prod + 24'(cfg.data_start_sector);
    actual = (left < 32'(cfg.cluster_bytes)) ? left[16:0] : cfg.cluster_bytes;

    res = '0;
    res.status = ST_DONE;
    case (act)
      ACT_OPEN: begin
        res.next_cluster = start_q;
      end
      ACT_READ: begin
        res.next_cluster = cur;
        if (at_end) begin
          res.status = ST_END;
        end else if (at_bad) begin
          res.status = ST_BAD;
        end else begin
          res.status         = ST_GIVEN;
          res.sector_address = sector;
          res.sector_count   = cfg.sectors_per_cluster;
          res.byte_count     = actual;
          res.next_cluster   = next_cl;
        end
      end
      default: ;
    endcase
  end

  assign st.out_free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      start_q <= item.start_cluster;
      size_q  <= item.file_size;
    end
    if (cmd.commit) begin
      result <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      act          <= ACT_LOAD;
      cur          <= 16'd0;
      left         <= 32'd0;
      result_valid <= 1'b0;
    end else begin
      if (cmd.capture) begin
        act <= item.action;
      end
      if (cmd.commit) begin
        result_valid <= 1'b1;
        if (act == ACT_OPEN) begin
          cur  <= start_q;
          left <= size_q;
        end else if (res.status == ST_GIVEN) begin
          cur  <= next_cl;
          left <= left - 32'(actual);
        end
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/fat_cluster_chain_reader.sv
// Top level of the FAT12/FAT16 cluster chain reader.
//
// The item channel (item_valid, item_stall, item) carries three kinds of
// transaction: a load writes one byte of the FAT copy, an open sets the
// file's first cluster and size, and a read returns the sector range and
// byte count of the current cluster and steps to the next one in the chain,
// or reports the chain's end or a bad cluster. Every item yields exactly
// one result transaction on the result channel (result_valid, result_stall,
// result), in order. On acceptance the even and odd byte banks read both
// FAT bytes of the current cluster's entry into their output registers;
// once the result register is free, the registered bytes form the result
// and update the chain. A new item is taken only after the previous one is
// committed, and the result appears on the ports the cycle after its commit.
// While the receiver stalls, the result register holds its transaction; the
// block still accepts one more item and parks it until the register frees
// up. Reset clears the chain state and the handshake and returns the
// configuration registers to their defaults; the FAT copy is not cleared and
// must be loaded before it is read. Configuration must be written over the
// APB-style port while the block is idle; the block does not enforce this.
`default_nettype none

module fat_cluster_chain_reader
  import fcc_pkg::*;
#(
  parameter int FAT_BYTES = FatBytesDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  output logic             item_stall,
  input  wire item_t       item,
  output logic             result_valid,
  input  wire logic        result_stall,
  output result_t          result,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t st;

  // Register file for format, cluster geometry and data start.
  fcc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // The controller sequences each transaction through capture and commit.
  fcc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .st         (st),
    .cmd        (cmd)
  );

  // The datapath holds the FAT banks, the chain state and the result register.
  fcc_dpath #(.FAT_BYTES(FAT_BYTES)) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cfg          (cfg),
    .cmd          (cmd),
    .st           (st),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  // Only one transaction is in flight, so acceptance is always followed by a stall.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) |=> item_stall)
    else $error("item accepted while the previous one was in flight");

  // A commit always loads the result register.
  a_commit_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> result_valid)
    else $error("committed result did not appear");

  // Only a cluster-given result carries sector and byte counts.
  a_counts_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result.status != ST_GIVEN)) |->
      (result.sector_count == 8'd0) && (result.byte_count == 17'd0))
    else $error("counts set on a result without a cluster");

endmodule

`default_nettype wire
